FILE: sv/ttd_pkg.sv
// ============================================================================
// ttd_pkg: shared types and constants for the tag-tree decoder
// Command and status codes, sequencer states, geometry status bundle.
// ============================================================================
package ttd_pkg;

    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_MAX_ROWS   = 32;
    localparam int DEF_VALUE_BITS = 16;

    localparam int CMD_W       = 2;
    localparam int LEAF_W      = 5;
    localparam int STATUS_W    = 2;
    localparam int OUT_VALUE_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    // Tree levels the address tables hold
    localparam int LEVEL_SLOTS = 8;
    localparam int LVL_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_START = 2'd1,
        CMD_BIT   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEED    = 2'd0,
        ST_READY   = 2'd1,
        ST_CLEARED = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_GEOM,
        S_IDLE,
        S_ADDR,
        S_READ,
        S_EVAL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             busy;
        logic [LVL_W-1:0] top_level;
    } geom_stat_t;

endpackage

FILE: sv/tag_tree_decoder.sv
// ============================================================================
// tag_tree_decoder: tag-tree decoder, one leaf walk at a time
// Sequencer over a single node memory; each level is read, compared against
// the running floor and written back before stepping to the next level.
// ============================================================================
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_stall   | cmd, leaf_row, leaf_col, header_bit
//  out      | out_valid / out_stall | status, leaf_value
//  cfg      | cfg_write             | cfg_index, cfg_data
//
//  Start: S_ADDR, S_READ, S_EVAL per level visited, then S_EMIT; a bit enters
//  at S_EVAL, then walks on. Each level costs an address, a memory read and a
//  read-modify-write of the node word through the one memory port pair.
//  Clear (and reset) sweeps all MAX_COLS*MAX_ROWS*2+8 nodes, one per cycle.
//  A grid size write reruns the level-table sweep before the next transaction.
//  in_stall is high unless idle with no grid size write pending; a finished
//  result waits in the output register while the next one is taken.
module tag_tree_decoder #(
    parameter int MAX_COLS   = ttd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = ttd_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = ttd_pkg::DEF_VALUE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ttd_pkg::CMD_W-1:0]       cmd,
    input  logic [ttd_pkg::LEAF_W-1:0]      leaf_row,
    input  logic [ttd_pkg::LEAF_W-1:0]      leaf_col,
    input  logic                            header_bit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ttd_pkg::STATUS_W-1:0]    status,
    output logic [ttd_pkg::OUT_VALUE_W-1:0] leaf_value,
    input  logic                            cfg_write,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ttd_pkg::*;

    localparam int NODE_COUNT = MAX_COLS * MAX_ROWS * 2 + 8;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int WORD_W     = 2 * VALUE_BITS;
    localparam int GW_W       = $clog2(MAX_COLS + 1);
    localparam int GH_W       = $clog2(MAX_ROWS + 1);
    localparam logic [VALUE_BITS-1:0] UNKNOWN = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] UNK_M1  = UNKNOWN - VALUE_BITS'(1);

    state_t                  state_reg, state_next;
    logic                    geom_pend_reg;
    logic                    clr_report_reg;
    logic                    decoding_reg;
    logic                    src_mem_reg;
    logic [LVL_W-1:0]        cur_level_reg;
    logic [LEAF_W-1:0]       tr_reg, tc_reg;
    logic [VALUE_BITS-1:0]   pm_reg, wf_reg, tv_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [ADDR_W-1:0]       clr_reg;
    status_t                 res_status_reg;
    logic [VALUE_BITS-1:0]   res_value_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [OUT_VALUE_W-1:0]  out_value_reg;

    logic [GW_W-1:0]         grid_w;
    logic [GH_W-1:0]         grid_h;
    geom_stat_t              geom_stat;
    logic [ADDR_W-1:0]       geom_addr;
    logic                    sweep_start;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [WORD_W-1:0]       mem_rdata;

    logic                    in_accept;
    logic                    out_load;
    logic                    clr_last;
    logic [VALUE_BITS-1:0]   rd_val, rd_fl;
    logic [VALUE_BITS-1:0]   ev_tv, ev_wf;
    logic                    settled;
    logic [VALUE_BITS-1:0]   bit_wf, bit_tv;
    logic [LEAF_W-1:0]       row_sat, col_sat;

    ttd_geom #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (ADDR_W)
    ) u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sweep_start (sweep_start),
        .level       (cur_level_reg),
        .target_row  (tr_reg),
        .target_col  (tc_reg),
        .grid_w      (grid_w),
        .grid_h      (grid_h),
        .geom_stat   (geom_stat),
        .node_addr   (geom_addr)
    );

    ttd_node_mem #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    // Node evaluation: fresh from memory on entering a level, held after a bit
    assign rd_val  = mem_rdata[WORD_W-1:VALUE_BITS];
    assign rd_fl   = mem_rdata[VALUE_BITS-1:0];
    assign ev_tv   = src_mem_reg ? rd_val : tv_reg;
    assign ev_wf   = src_mem_reg ? ((rd_fl > pm_reg) ? rd_fl : pm_reg) : wf_reg;
    assign settled = !(ev_tv > ev_wf);

    assign bit_wf = (!header_bit && wf_reg < UNK_M1) ? wf_reg + VALUE_BITS'(1) : wf_reg;
    assign bit_tv = header_bit ? wf_reg : tv_reg;

    assign row_sat = (32'(leaf_row) < 32'(grid_h)) ? leaf_row : LEAF_W'(grid_h - GH_W'(1));
    assign col_sat = (32'(leaf_col) < 32'(grid_w)) ? leaf_col : LEAF_W'(grid_w - GW_W'(1));

    assign clr_last  = (clr_reg == ADDR_W'(NODE_COUNT - 1));
    assign in_accept = in_valid && !in_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                    state_next = clr_report_reg ? S_EMIT : S_IDLE;
            end
            S_GEOM:
            begin
                if (!geom_stat.busy)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (geom_pend_reg)
                    state_next = S_GEOM;
                else if (in_valid)
                begin
                    unique case (cmd)
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_START: state_next = S_ADDR;
                        CMD_BIT:   state_next = decoding_reg ? S_EVAL : S_EMIT;
                        default:   state_next = S_EMIT;
                    endcase
                end
            end
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_EVAL;
            S_EVAL:
            begin
                if (settled && cur_level_reg != '0)
                    state_next = S_ADDR;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall    = !(state_reg == S_IDLE && !geom_pend_reg);
        sweep_start = (state_reg == S_IDLE) && geom_pend_reg;
        out_load    = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = {ev_tv, ev_wf};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {UNKNOWN, {VALUE_BITS{1'b0}}};
            end
            S_EVAL:
            begin
                // a bit always rewrites the floor; a fresh node only once settled
                mem_we = settled || !src_mem_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            geom_pend_reg  <= 1'b1;
            clr_report_reg <= 1'b0;
            decoding_reg   <= 1'b0;
            src_mem_reg    <= 1'b1;
            cur_level_reg  <= '0;
            tr_reg         <= '0;
            tc_reg         <= '0;
            pm_reg         <= '0;
            wf_reg         <= '0;
            tv_reg         <= '0;
            addr_reg       <= '0;
            clr_reg        <= '0;
            res_status_reg <= ST_NEED;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NEED;
            out_value_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
                geom_pend_reg <= 1'b1;
            else if (sweep_start)
                geom_pend_reg <= 1'b0;

            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
                if (clr_last)
                    clr_report_reg <= 1'b0;
            end

            if (in_accept)
            begin
                res_value_reg <= '0;
                unique case (cmd)
                    CMD_CLEAR:
                    begin
                        clr_reg        <= '0;
                        clr_report_reg <= 1'b1;
                        res_status_reg <= ST_CLEARED;
                    end
                    CMD_START:
                    begin
                        tr_reg        <= row_sat;
                        tc_reg        <= col_sat;
                        cur_level_reg <= geom_stat.top_level;
                        pm_reg        <= '0;
                        src_mem_reg   <= 1'b1;
                    end
                    CMD_BIT:
                    begin
                        if (decoding_reg)
                        begin
                            wf_reg      <= bit_wf;
                            tv_reg      <= bit_tv;
                            src_mem_reg <= 1'b0;
                        end
                        else
                            res_status_reg <= ST_IGNORED;
                    end
                    default: res_status_reg <= ST_IGNORED;
                endcase
            end

            if (cfg_write)
                decoding_reg <= 1'b0;
            else if (in_accept && cmd == CMD_CLEAR)
                decoding_reg <= 1'b0;
            else if (in_accept && cmd == CMD_START)
                decoding_reg <= 1'b1;
            else if (state_reg == S_EVAL && settled && cur_level_reg == '0)
                decoding_reg <= 1'b0;

            if (state_reg == S_ADDR)
                addr_reg <= geom_addr;

            if (state_reg == S_EVAL)
            begin
                tv_reg <= ev_tv;
                wf_reg <= ev_wf;
                if (!settled)
                begin
                    res_status_reg <= ST_NEED;
                    res_value_reg  <= '0;
                end
                else if (cur_level_reg == '0)
                begin
                    res_status_reg <= ST_READY;
                    res_value_reg  <= ev_tv;
                end
                else
                begin
                    // path minimum becomes the starting floor one level down
                    pm_reg        <= (ev_tv < ev_wf) ? ev_tv : ev_wf;
                    cur_level_reg <= cur_level_reg - LVL_W'(1);
                    src_mem_reg   <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_value_reg  <= OUT_VALUE_W'(res_value_reg);
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign leaf_value = out_value_reg;

    a_leaf_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && settled && cur_level_reg == '0)
        |=> (!decoding_reg && state_reg == S_EMIT))
        else $error("leaf settled but walk not closed");

    a_floor_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (ev_wf <= UNK_M1))
        else $error("node floor beyond saturation limit");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR) |-> (cur_level_reg <= geom_stat.top_level))
        else $error("walk level above tree root");

    a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (32'(clr_reg) < NODE_COUNT))
        else $error("clear sweep ran past node memory");

endmodule

FILE: sv/ttd_node_mem.sv
// ============================================================================
// ttd_node_mem: node storage for the tag tree
// One write port, one read port, registered read data. Word is {value, floor}.
// ============================================================================
module ttd_node_mem #(
    parameter int DEPTH  = 2056,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ttd_geom.sv
// ============================================================================
// ttd_geom: grid geometry and node addressing
// Holds the grid size registers, sweeps the per-level width and base offset
// tables one level per cycle, and forms the node address for a level.
// ============================================================================
module ttd_geom #(
    parameter int MAX_COLS = ttd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ttd_pkg::DEF_MAX_ROWS,
    parameter int ADDR_W   = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           sweep_start,
    input  logic [ttd_pkg::LVL_W-1:0]      level,
    input  logic [ttd_pkg::LEAF_W-1:0]     target_row,
    input  logic [ttd_pkg::LEAF_W-1:0]     target_col,
    output logic [$clog2(MAX_COLS+1)-1:0]  grid_w,
    output logic [$clog2(MAX_ROWS+1)-1:0]  grid_h,
    output ttd_pkg::geom_stat_t            geom_stat,
    output logic [ADDR_W-1:0]              node_addr
);
    import ttd_pkg::*;

    localparam int GW_W   = $clog2(MAX_COLS + 1);
    localparam int GH_W   = $clog2(MAX_ROWS + 1);
    localparam int PROD_W = GW_W + GH_W;
    localparam int SWW    = GW_W + LEVEL_SLOTS;
    localparam int SHW    = GH_W + LEVEL_SLOTS;
    localparam int RP_W   = LEAF_W + GW_W;

    logic [GW_W-1:0]   gw_reg;
    logic [GH_W-1:0]   gh_reg;
    logic              busy_reg;
    logic [LVL_W-1:0]  k_reg;
    logic [LVL_W-1:0]  top_reg;
    logic [GW_W-1:0]   lw_reg  [LEVEL_SLOTS];
    logic [ADDR_W-1:0] off_reg [LEVEL_SLOTS];

    logic [SWW-1:0]    wk_wide;
    logic [SHW-1:0]    hk_wide;
    logic [GW_W-1:0]   wk;
    logic [GH_W-1:0]   hk;
    logic [PROD_W-1:0] area;
    logic [LEAF_W-1:0] row_sh;
    logic [LEAF_W-1:0] col_sh;
    logic [RP_W-1:0]   row_prod;

    // 0 reads as 1, anything above the limit as the limit
    function automatic logic [GW_W-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
        logic [GW_W-1:0] r;
        if (v == '0)
            r = GW_W'(1);
        else if (32'(v) > MAX_COLS)
            r = GW_W'(MAX_COLS);
        else
            r = GW_W'(v);
        return r;
    endfunction

    function automatic logic [GH_W-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
        logic [GH_W-1:0] r;
        if (v == '0)
            r = GH_W'(1);
        else if (32'(v) > MAX_ROWS)
            r = GH_W'(MAX_ROWS);
        else
            r = GH_W'(v);
        return r;
    endfunction

    // ceil(size / 2^k) for the level under sweep
    assign wk_wide = (SWW'(gw_reg) + ((SWW'(1) << k_reg) - SWW'(1))) >> k_reg;
    assign hk_wide = (SHW'(gh_reg) + ((SHW'(1) << k_reg) - SHW'(1))) >> k_reg;
    assign wk      = GW_W'(wk_wide);
    assign hk      = GH_W'(hk_wide);
    assign area    = PROD_W'(wk) * PROD_W'(hk);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= GW_W'(1);
            gh_reg   <= GH_W'(1);
            busy_reg <= 1'b0;
            k_reg    <= '0;
            top_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg <= clamp_w(cfg_data);
                    CFG_GRID_HEIGHT: gh_reg <= clamp_h(cfg_data);
                    default: ;
                endcase
            end
            if (sweep_start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
                top_reg  <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + LVL_W'(1);
                if (k_reg == LVL_W'(LEVEL_SLOTS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else if (wk > GW_W'(1) || hk > GH_W'(1))
                begin
                    top_reg <= k_reg + LVL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_start)
        begin
            off_reg[0] <= '0;
        end
        else if (busy_reg)
        begin
            lw_reg[k_reg] <= wk;
            if (k_reg != LVL_W'(LEVEL_SLOTS - 1))
            begin
                off_reg[k_reg + LVL_W'(1)] <= off_reg[k_reg] + ADDR_W'(area);
            end
        end
    end

    assign row_sh   = target_row >> level;
    assign col_sh   = target_col >> level;
    assign row_prod = RP_W'(row_sh) * RP_W'(lw_reg[level]);
    assign node_addr = off_reg[level] + ADDR_W'(row_prod) + ADDR_W'(col_sh);

    assign grid_w              = gw_reg;
    assign grid_h              = gh_reg;
    assign geom_stat.busy      = busy_reg;
    assign geom_stat.top_level = top_reg;

endmodule
